FILE: rtl/nbbr_pkg.sv
package nbbr_pkg;

	localparam int PAGE_BYTES      = 2048;
	localparam int PAGES_PER_BLOCK = 64;
	localparam int BLOCK_COUNT     = 512;

	localparam int COL_W   = $clog2(PAGE_BYTES);
	localparam int PIB_W   = $clog2(PAGES_PER_BLOCK);
	localparam int BOFF_W  = COL_W + PIB_W;
	localparam int IDX_W   = $clog2(BLOCK_COUNT);
	localparam int CNT_W   = IDX_W + 1;
	localparam int ADDR_W  = 26;
	localparam int LEN_W   = 16;
	localparam int CHUNK_W = COL_W + 1;
	localparam int PAGE_W  = IDX_W + PIB_W;
	localparam int WADDR_W = ADDR_W + 1;

	localparam logic [7:0] MARK_GOOD = 8'hFF;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SCAN  = 2'd1;
	localparam logic [1:0] OP_RANGE = 2'd2;
	localparam logic [1:0] OP_ERASE = 2'd3;

	localparam logic [1:0] KIND_SCAN  = 2'd0;
	localparam logic [1:0] KIND_CHUNK = 2'd1;
	localparam logic [1:0] KIND_ERASE = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	typedef struct packed {
		logic             clear;
		logic             append;
		logic [IDX_W-1:0] block;
	} tbl_cmd_t;

endpackage

FILE: rtl/nbbr_table.sv
module nbbr_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nbbr_pkg::tbl_cmd_t        cmd,
	input  logic [nbbr_pkg::IDX_W-1:0] rd_index,
	output logic [nbbr_pkg::IDX_W-1:0] rd_entry,
	output logic [nbbr_pkg::CNT_W-1:0] total
);
	import nbbr_pkg::*;

	logic [IDX_W-1:0] mem [BLOCK_COUNT];
	logic [IDX_W-1:0] rd_entry_q;
	logic [CNT_W-1:0] total_q;
	logic             full;
	logic             do_write;

	assign full     = (total_q == CNT_W'(BLOCK_COUNT));
	assign do_write = cmd.append && !full;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[total_q[IDX_W-1:0]] <= cmd.block;
		end
		rd_entry_q <= mem[rd_index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.clear) begin
			total_q <= '0;
		end else if (do_write) begin
			total_q <= total_q + CNT_W'(1);
		end
	end

	assign rd_entry = rd_entry_q;
	assign total    = total_q;

endmodule

FILE: rtl/nand_bad_block_remap.sv
// Keeps a compacted table of good NAND blocks and maps logical byte ranges onto
// physical pages through it. Items are taken one at a time; req_ready is high
// only while the block is idle. A clear item gives no result. A scan item gives
// one acknowledge result. A range item gives its page chunks one after another,
// each through address decode, table read and result load, and starts the next
// chunk only once the last one is taken, up to 33 chunks; an erase item gives one
// erase result. An unmapped logical block gives an error result that ends the
// item. Every result sits in an output register until transferred, and good_count
// on each result reports the table size at that time.
module nand_bad_block_remap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    opcode,
	input  logic [nbbr_pkg::IDX_W-1:0]    block_index,
	input  logic                          read_failed,
	input  logic [7:0]                    marker_first,
	input  logic [7:0]                    marker_second,
	input  logic [nbbr_pkg::ADDR_W-1:0]   logical_address,
	input  logic [nbbr_pkg::LEN_W-1:0]    byte_length,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [1:0]                    kind,
	output logic [nbbr_pkg::PAGE_W-1:0]   physical_page,
	output logic [nbbr_pkg::COL_W-1:0]    column,
	output logic [nbbr_pkg::CHUNK_W-1:0]  chunk_bytes,
	output logic                          whole_page,
	output logic [nbbr_pkg::CNT_W-1:0]    good_count,
	output logic                          last
);
	import nbbr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK,
		ST_LOOK,
		ST_READ,
		ST_HOLD
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic [WADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]   len_q;
	logic               done_q;
	logic               valid_q;
	logic [1:0]         kind_q;
	logic [PAGE_W-1:0]  page_q;
	logic [COL_W-1:0]   col_q;
	logic [CHUNK_W-1:0] bytes_q;
	logic               whole_q;
	logic [CNT_W-1:0]   count_q;
	logic               last_q;

	tbl_cmd_t           cmd;
	logic [IDX_W-1:0]   entry;
	logic [CNT_W-1:0]   total;
	logic [CNT_W-1:0]   blk;
	logic               unmapped;
	logic [COL_W-1:0]   col;
	logic [CHUNK_W-1:0] room;
	logic [CHUNK_W-1:0] chunk;
	logic               take;
	logic               good;

	assign take     = req_valid && req_ready;
	assign good     = !read_failed && (marker_first == MARK_GOOD)
		&& (marker_second == MARK_GOOD);
	assign blk      = addr_q[WADDR_W-1:BOFF_W];
	assign unmapped = (blk >= total);
	assign col      = addr_q[COL_W-1:0];
	assign room     = CHUNK_W'(PAGE_BYTES) - {1'b0, col};
	assign chunk    = ({{(LEN_W-CHUNK_W){1'b0}}, room} > len_q) ? len_q[CHUNK_W-1:0] : room;

	always_comb begin
		cmd        = '0;
		cmd.clear  = take && (opcode == OP_CLEAR);
		cmd.append = take && (opcode == OP_SCAN) && good;
		cmd.block  = block_index;
	end

	nbbr_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_index (blk[IDX_W-1:0]),
		.rd_entry (entry),
		.total    (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			op_q    <= OP_CLEAR;
			addr_q  <= '0;
			len_q   <= '0;
			kind_q  <= KIND_SCAN;
			page_q  <= '0;
			col_q   <= '0;
			bytes_q <= '0;
			whole_q <= 1'b0;
			count_q <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						op_q   <= opcode;
						addr_q <= {1'b0, logical_address};
						len_q  <= byte_length;
						case (opcode)
							OP_SCAN: state_q <= ST_ACK;
							OP_RANGE, OP_ERASE: begin
								if (byte_length != '0) begin
									state_q <= ST_LOOK;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ACK: begin
					kind_q  <= KIND_SCAN;
					page_q  <= '0;
					col_q   <= '0;
					bytes_q <= '0;
					whole_q <= 1'b0;
					count_q <= total;
					last_q  <= 1'b1;
					done_q  <= 1'b1;
					valid_q <= 1'b1;
					state_q <= ST_HOLD;
				end
				ST_LOOK: begin
					if (unmapped) begin
						kind_q  <= KIND_ERROR;
						page_q  <= '0;
						col_q   <= '0;
						bytes_q <= '0;
						whole_q <= 1'b0;
						count_q <= total;
						last_q  <= 1'b1;
						done_q  <= 1'b1;
						valid_q <= 1'b1;
						state_q <= ST_HOLD;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					count_q <= total;
					valid_q <= 1'b1;
					state_q <= ST_HOLD;
					if (op_q == OP_ERASE) begin
						kind_q  <= KIND_ERASE;
						page_q  <= {entry, {PIB_W{1'b0}}};
						col_q   <= '0;
						bytes_q <= '0;
						whole_q <= 1'b0;
						last_q  <= 1'b1;
						done_q  <= 1'b1;
					end else begin
						kind_q  <= KIND_CHUNK;
						page_q  <= {entry, addr_q[BOFF_W-1:COL_W]};
						col_q   <= col;
						bytes_q <= chunk;
						whole_q <= (col == '0) && (chunk == CHUNK_W'(PAGE_BYTES));
						last_q  <= (len_q == LEN_W'(chunk));
						done_q  <= (len_q == LEN_W'(chunk));
						addr_q  <= addr_q + WADDR_W'(chunk);
						len_q   <= len_q - LEN_W'(chunk);
					end
				end
				ST_HOLD: begin
					if (rsp_ready) begin
						valid_q <= 1'b0;
						state_q <= done_q ? ST_IDLE : ST_LOOK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready     = (state_q == ST_IDLE);
	assign rsp_valid     = valid_q;
	assign kind          = kind_q;
	assign physical_page = page_q;
	assign column        = col_q;
	assign chunk_bytes   = bytes_q;
	assign whole_page    = whole_q;
	assign good_count    = count_q;
	assign last          = last_q;

endmodule

FILE: tb/sv/tb_nand_bad_block_remap.sv
module tb_nand_bad_block_remap;
	import nbbr_pkg::*;

	localparam int unsigned BLOCK_BYTES = PAGE_BYTES * PAGES_PER_BLOCK;
	localparam int MAX_RSPS = 33;
	localparam int CYCLE_LIMIT = 10_000_000;

	typedef struct {
		logic [1:0]  op;
		logic [8:0]  blk;
		logic        fail;
		logic [7:0]  mark_first;
		logic [7:0]  mark_second;
		logic [25:0] addr;
		logic [15:0] len;
	} remap_req_t;

	typedef struct {
		logic [1:0]  kind;
		logic [14:0] page;
		logic [10:0] col;
		logic [11:0] bytes;
		logic        whole;
		logic [9:0]  count;
		logic        last;
	} remap_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  opcode;
	logic [8:0]  block_index;
	logic        read_failed;
	logic [7:0]  marker_first;
	logic [7:0]  marker_second;
	logic [25:0] logical_address;
	logic [15:0] byte_length;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [1:0]  kind;
	logic [14:0] physical_page;
	logic [10:0] column;
	logic [11:0] chunk_bytes;
	logic        whole_page;
	logic [9:0]  good_count;
	logic        last;

	logic [8:0]  good_blocks [BLOCK_COUNT];
	logic [9:0]  good_total = '0;
	remap_rsp_t  pending_rsps[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          hold_off_cycles = 0;
	bit          quiet = 1'b0;

	nand_bad_block_remap u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic remap_rsp_t make_rsp(logic [1:0] k, int unsigned page, int unsigned col,
			int unsigned bytes, logic whole);
		remap_rsp_t rsp;
		rsp.kind  = k;
		rsp.page  = 15'(page);
		rsp.col   = 11'(col);
		rsp.bytes = 12'(bytes);
		rsp.whole = whole;
		rsp.count = good_total;
		rsp.last  = 1'b0;
		return rsp;
	endfunction

	function automatic void predict_remap(input remap_req_t r);
		remap_rsp_t  rsps[$];
		logic        good;
		int unsigned addr;
		int unsigned len;
		int unsigned blk;
		int unsigned off;
		int unsigned col;
		int unsigned chunk;
		addr = 32'(r.addr);
		len  = 32'(r.len);
		case (r.op)
			OP_CLEAR: good_total = '0;
			OP_SCAN: begin
				good = !r.fail && r.mark_first == MARK_GOOD && r.mark_second == MARK_GOOD;
				if (good && good_total < BLOCK_COUNT) begin
					good_blocks[good_total] = r.blk;
					good_total++;
				end
				rsps.push_back(make_rsp(KIND_SCAN, 0, 0, 0, 1'b0));
			end
			OP_RANGE: begin
				while (len > 0 && rsps.size() < MAX_RSPS) begin
					blk   = addr / BLOCK_BYTES;
					off   = addr % BLOCK_BYTES;
					col   = off % PAGE_BYTES;
					chunk = PAGE_BYTES - col;
					if (blk >= good_total) begin
						rsps.push_back(make_rsp(KIND_ERROR, 0, 0, 0, 1'b0));
						break;
					end
					if (chunk > len)
						chunk = len;
					rsps.push_back(make_rsp(KIND_CHUNK,
						good_blocks[blk] * PAGES_PER_BLOCK + off / PAGE_BYTES, col, chunk,
						col == 0 && chunk == PAGE_BYTES));
					addr += chunk;
					len  -= chunk;
				end
			end
			default: begin
				while (len > 0 && rsps.size() < MAX_RSPS) begin
					blk = addr / BLOCK_BYTES;
					if (blk >= good_total) begin
						rsps.push_back(make_rsp(KIND_ERROR, 0, 0, 0, 1'b0));
						break;
					end
					rsps.push_back(make_rsp(KIND_ERASE, good_blocks[blk] * PAGES_PER_BLOCK,
						0, 0, 1'b0));
					addr += BLOCK_BYTES;
					len = (len >= BLOCK_BYTES) ? len - BLOCK_BYTES : 0;
				end
			end
		endcase
		if (rsps.size() > 0)
			rsps[$].last = 1'b1;
		foreach (rsps[i])
			pending_rsps.push_back(rsps[i]);
	endfunction

	// enter and leave at a falling edge
	task automatic send_req(input remap_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode          <= r.op;
		block_index     <= r.blk;
		read_failed     <= r.fail;
		marker_first    <= r.mark_first;
		marker_second   <= r.mark_second;
		logical_address <= r.addr;
		byte_length     <= r.len;
		req_valid       <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		predict_remap(r);
		@(negedge clk);
	endtask

	task automatic send_scan(logic [8:0] blk, logic fail, logic [7:0] m1, logic [7:0] m2);
		remap_req_t r;
		r.op          = OP_SCAN;
		r.blk         = blk;
		r.fail        = fail;
		r.mark_first  = m1;
		r.mark_second = m2;
		r.addr        = 26'($urandom());
		r.len         = 16'($urandom());
		send_req(r);
	endtask

	task automatic send_span(logic [1:0] op, logic [25:0] addr, logic [15:0] len);
		remap_req_t r;
		r.op          = op;
		r.blk         = 9'($urandom());
		r.fail        = 1'($urandom());
		r.mark_first  = 8'($urandom());
		r.mark_second = 8'($urandom());
		r.addr        = addr;
		r.len         = len;
		send_req(r);
	endtask

	task automatic send_random_scan();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			send_scan(9'($urandom()), 1'b0, MARK_GOOD, MARK_GOOD);
		else if (sel == 7)
			send_scan(9'($urandom()), 1'b1, 8'($urandom()), 8'($urandom()));
		else if (sel == 8)
			send_scan(9'($urandom()), 1'($urandom()), 8'($urandom_range(0, 254)),
				8'($urandom()));
		else
			send_scan(9'($urandom()), 1'($urandom()), 8'($urandom()),
				8'($urandom_range(0, 254)));
	endtask

	task automatic send_random_span(logic [1:0] op);
		logic [8:0]  blk;
		logic [16:0] low;
		logic [15:0] len;
		int          sel;
		if (good_total > 0 && $urandom_range(0, 9) < 8)
			blk = 9'($urandom_range(0, good_total - 1));
		else
			blk = 9'($urandom());
		low = 17'($urandom());
		if ($urandom_range(0, 3) == 0)
			low[10:0] = '0;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			len = '0;
		else if (sel < 50)
			len = 16'($urandom_range(1, 4096));
		else if (sel < 80)
			len = 16'($urandom_range(1, 65535));
		else if (sel < 90)
			len = 16'($urandom_range(1, 31) * PAGE_BYTES);
		else
			len = 16'hFFFF;
		send_span(op, {blk, low}, len);
	endtask

	task automatic test_clear_and_scan();
		send_span(OP_CLEAR, '0, '0);
		send_span(OP_RANGE, '0, 16'd100);
		send_scan(9'd0, 1'b0, MARK_GOOD, MARK_GOOD);
		send_scan(9'd5, 1'b1, MARK_GOOD, MARK_GOOD);
		send_scan(9'd6, 1'b0, 8'hFE, MARK_GOOD);
		send_scan(9'd7, 1'b0, MARK_GOOD, 8'h7F);
		send_scan(9'd8, 1'b1, 8'h00, 8'h00);
		send_scan(9'd511, 1'b0, MARK_GOOD, MARK_GOOD);
		send_scan(9'h155, 1'b0, MARK_GOOD, MARK_GOOD);
		send_scan(9'h0AA, 1'b0, MARK_GOOD, MARK_GOOD);
	endtask

	task automatic test_directed_spans();
		send_span(OP_RANGE, '0, 16'd2048);
		send_span(OP_RANGE, '0, '0);
		send_span(OP_RANGE, 26'd2047, 16'hFFFF);
		send_span(OP_RANGE, 26'(BLOCK_BYTES - 3000), 16'd8000);
		send_span(OP_RANGE, 26'(4 * BLOCK_BYTES - 1000), 16'd5000);
		send_span(OP_RANGE, 26'h3FFFFFF, 16'hFFFF);
		send_span(OP_ERASE, '0, 16'd1);
		send_span(OP_ERASE, 26'(BLOCK_BYTES + 77), 16'hFFFF);
		send_span(OP_ERASE, '0, '0);
		send_span(OP_ERASE, 26'(3 * BLOCK_BYTES + 5), 16'd200);
		send_span(OP_ERASE, 26'(4 * BLOCK_BYTES), 16'd1);
	endtask

	task automatic test_table_full();
		send_span(OP_CLEAR, 26'($urandom()), 16'($urandom()));
		repeat (BLOCK_COUNT)
			send_scan(9'($urandom()), 1'b0, MARK_GOOD, MARK_GOOD);
		send_scan(9'($urandom()), 1'b0, MARK_GOOD, MARK_GOOD);
		send_scan(9'($urandom()), 1'b1, MARK_GOOD, MARK_GOOD);
		send_span(OP_RANGE, 26'(26'h3FFFFFF - 100), 16'd300);
		send_span(OP_ERASE, 26'h3FFFFFF, 16'd1);
	endtask

	task automatic test_output_stall();
		hold_off_cycles = 300;
		repeat (4)
			send_random_span(OP_RANGE);
		send_random_scan();
		send_random_span(OP_ERASE);
	endtask

	task automatic test_random_traffic(int count);
		int sent;
		int sel;
		int refill;
		sent = 0;
		while (sent < count) begin
			quiet = (sent >= 100 && sent < 150);
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				send_span(OP_CLEAR, 26'($urandom()), 16'($urandom()));
				refill = $urandom_range(1, 40);
				repeat (refill)
					send_random_scan();
				sent += refill + 1;
			end else if (sel < 20) begin
				send_random_scan();
				sent++;
			end else if (sel < 72) begin
				send_random_span(OP_RANGE);
				sent++;
			end else begin
				send_random_span(OP_ERASE);
				sent++;
			end
		end
		quiet = 1'b0;
	endtask

	initial begin : rsp_side
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else begin
				rsp_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : rsp_check
		remap_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				$error("unexpected transfer: kind %0d page %0d", kind, physical_page);
				mismatch_count++;
			end else begin
				want = pending_rsps.pop_front();
				check_field("kind", want.kind, kind);
				check_field("physical_page", want.page, physical_page);
				check_field("column", want.col, column);
				check_field("chunk_bytes", want.bytes, chunk_bytes);
				check_field("whole_page", want.whole, whole_page);
				check_field("good_count", want.count, good_count);
				check_field("last", want.last, last);
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		opcode          = OP_CLEAR;
		block_index     = '0;
		read_failed     = 1'b0;
		marker_first    = '0;
		marker_second   = '0;
		logical_address = '0;
		byte_length     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_clear_and_scan();
		test_directed_spans();
		test_table_full();
		test_output_stall();
		test_random_traffic(300);
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
rtl/nbbr_pkg.sv
rtl/nbbr_table.sv
rtl/nand_bad_block_remap.sv
tb/sv/tb_nand_bad_block_remap.sv
